### hdl/lpss_pkg.sv
// Package: widths, codes and constants shared by the laser power scaler.
`timescale 1ns / 1ps
package lpss_pkg;

  localparam int unsigned OPCODE_W   = 2;
  localparam int unsigned S_W        = 16;
  localparam int unsigned RATE_W     = 24;
  localparam int unsigned HUND_W     = 14;
  localparam int unsigned FMS_W      = 24;
  localparam int unsigned POWER_W    = 17;
  localparam int unsigned SCALE_W    = 10;
  localparam int unsigned TICK_W     = 10;

  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 17;

  localparam int unsigned IN_TDATA_W  = 104;
  localparam int unsigned OUT_TDATA_W = 24;

  // Shared serial datapath widths.
  localparam int unsigned ACC_W   = 60;
  localparam int unsigned MCAND_W = 36;
  localparam int unsigned MLT_W   = 24;
  localparam int unsigned DVS_W   = 24;
  localparam int unsigned CNT_W   = 6;

  localparam logic [POWER_W-1:0] FULL_Q16   = 17'd65536;
  localparam logic [ACC_W-1:0]   POWER_CAP  = 60'd17179869184;
  localparam logic [DVS_W-1:0]   PCT_DIV    = 24'd100;
  localparam logic [DVS_W-1:0]   HUND_DIV   = 24'd10000;
  localparam logic [HUND_W-1:0]  HUND_MAX   = 14'd10000;

  typedef enum logic [OPCODE_W-1:0] {
    OP_TICK     = 2'd0,
    OP_FIRE     = 2'd1,
    OP_FIRE_OFF = 2'd2,
    OP_HALT     = 2'd3
  } opcode_e;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_MAX_POWER   = 3'd0,
    CFG_MIN_POWER   = 3'd1,
    CFG_MAX_S_LEVEL = 3'd2,
    CFG_SCALE_PCT   = 3'd3,
    CFG_TICK_MS     = 3'd4,
    CFG_PWM_INVERT  = 3'd5,
    CFG_TTL_PRESENT = 3'd6,
    CFG_TTL_INVERT  = 3'd7
  } cfg_idx_e;

endpackage

### hdl/laser_power_speed_scaler_top.sv
// Laser power scaler: PWM duty and TTL enable from S level, speed ratio and manual fire.
//
// Input stream s_axis_*: one transaction per command; s_axis_tuser carries the opcode
// (tick, manual fire, fire off, halt), s_axis_tdata the command fields.
// Output stream m_axis_*: exactly one transaction per accepted command, carrying the
// duty, TTL level and status flags after the command took effect.
// Configuration: cfg_we_i writes cfg_wdata_i into register cfg_addr_i;
// write only while the block is idle.
// Fire off, halt, manual ticks, ticks without a move and refused fires go straight to
// the output. A manual fire divides the power by 10000, a timed one then the duration
// by the tick. A tick with an active move runs one bit-serial restoring divider and
// shift-add multiplier, one bit per cycle, through up to six passes in turn (divide by
// max S level, multiply by scale, divide by 100, multiply by axis rate, divide by nominal
// rate unless it is zero, multiply by power span). One command is in work at a time.
// The next command is taken while a result still waits in the output register; when
// the receiver stalls, a finished result holds in the block until that register frees.
// Reset restores the default registers, turns the laser off and leaves manual mode.
`timescale 1ns / 1ps
module laser_power_speed_scaler_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // move_active, s_level, axis_rate, nominal_step_rate, fire_power_hundredths, fire_ms
  input  logic [lpss_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // opcode
  input  logic [lpss_pkg::OPCODE_W-1:0]     s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // pwm_duty, ttl_level, beam_on, manual_mode, fire_rejected, zero fill
  output logic [lpss_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  input  logic                              cfg_we_i,
  input  logic [lpss_pkg::CFG_ADDR_W-1:0]   cfg_addr_i,
  input  logic [lpss_pkg::CFG_DATA_W-1:0]   cfg_wdata_i
);
  import lpss_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_REQ_DIV,
    ST_SCL_MUL,
    ST_PCT_DIV,
    ST_AXIS_MUL,
    ST_RATE_DIV,
    ST_SPAN_MUL,
    ST_MAP,
    ST_FIRE_DIV,
    ST_ROUND_DIV,
    ST_OUT
  } state_e;

  state_e state_q;

  logic [POWER_W-1:0] max_power_q, min_power_q;
  logic [S_W-1:0]     max_s_q;
  logic [SCALE_W-1:0] scale_q;
  logic [TICK_W-1:0]  tick_ms_q;
  logic               pwm_inv_q, ttl_pres_q, ttl_inv_q;

  logic               beam_q, manual_q;
  logic [FMS_W-1:0]   fire_rem_q;
  logic [POWER_W-1:0] duty_q;
  logic               rej_q;

  logic [RATE_W-1:0]  axis_q, nom_q;
  logic [FMS_W-1:0]   fms_q;

  logic [ACC_W-1:0]   acc_q;
  logic [DVS_W-1:0]   rem_q;
  logic [DVS_W-1:0]   dvs_q;
  logic [MCAND_W-1:0] mcand_q;
  logic [MLT_W-1:0]   mlt_q;
  logic [CNT_W-1:0]   cnt_q;

  logic                    out_valid_q;
  logic [OUT_TDATA_W-1:0]  out_data_q;

  // Input field views.
  logic               in_move;
  logic [S_W-1:0]     in_s;
  logic [RATE_W-1:0]  in_axis, in_nom;
  logic [HUND_W-1:0]  in_hund;
  logic [FMS_W-1:0]   in_fms;
  opcode_e            in_op;

  assign in_move = s_axis_tdata[0];
  assign in_s    = s_axis_tdata[16:1];
  assign in_axis = s_axis_tdata[40:17];
  assign in_nom  = s_axis_tdata[64:41];
  assign in_hund = s_axis_tdata[78:65];
  assign in_fms  = s_axis_tdata[102:79];
  assign in_op   = opcode_e'(s_axis_tuser);

  // Derived values.
  logic [TICK_W-1:0]  tick_w;
  logic [S_W-1:0]     max_s_w;
  logic [HUND_W-1:0]  hund_sat;
  logic [FMS_W-1:0]   rem_dec;
  logic               span_up;
  logic [POWER_W-1:0] span;

  assign tick_w   = (tick_ms_q == '0) ? TICK_W'(1) : tick_ms_q;
  assign max_s_w  = (max_s_q == '0) ? S_W'(1) : max_s_q;
  assign hund_sat = (in_hund > HUND_MAX) ? HUND_MAX : in_hund;
  assign rem_dec  = (fire_rem_q > FMS_W'(tick_w)) ? fire_rem_q - FMS_W'(tick_w) : '0;
  assign span_up  = (max_power_q >= min_power_q);
  assign span     = span_up ? max_power_q - min_power_q : min_power_q - max_power_q;

  // One restoring-divide step and one shift-add multiply step on the shared accumulator.
  logic [DVS_W:0]     r_sh;
  logic [DVS_W+1:0]   diff;
  logic               ge;
  logic [DVS_W-1:0]   rem_d;
  logic [ACC_W-1:0]   div_d;
  logic [ACC_W-1:0]   mul_d;
  logic [ACC_W-1:0]   cap_d;

  always_comb begin
    r_sh  = {rem_q, acc_q[ACC_W-1]};
    diff  = {1'b0, r_sh} - {2'b00, dvs_q};
    ge    = ~diff[DVS_W+1];
    rem_d = ge ? diff[DVS_W-1:0] : r_sh[DVS_W-1:0];
    div_d = {acc_q[ACC_W-2:0], ge};
    mul_d = {acc_q[ACC_W-2:0], 1'b0}
          + (mlt_q[MLT_W-1] ? {{(ACC_W-MCAND_W){1'b0}}, mcand_q} : '0);
    cap_d = (div_d > POWER_CAP) ? POWER_CAP : div_d;
  end

  // Map the scaled power into the duty range and clamp.
  logic [35:0]        span_prod;
  logic [36:0]        up_sum;
  logic [POWER_W-1:0] down_val;
  logic [POWER_W-1:0] map_duty;

  always_comb begin
    span_prod = acc_q[51:16];
    up_sum    = {20'b0, min_power_q} + {1'b0, span_prod};
    down_val  = min_power_q - span_prod[POWER_W-1:0];
    if (span_up) begin
      map_duty = (up_sum > 37'(FULL_Q16)) ? FULL_Q16 : up_sum[POWER_W-1:0];
    end else if (span_prod >= 36'(min_power_q)) begin
      map_duty = '0;
    end else begin
      map_duty = (down_val > FULL_Q16) ? FULL_Q16 : down_val;
    end
  end

  logic last_step;
  logic out_free;
  assign last_step = (cnt_q == CNT_W'(1));
  assign out_free  = ~out_valid_q | m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_power_q <= FULL_Q16;
      min_power_q <= '0;
      max_s_q     <= S_W'(2048);
      scale_q     <= SCALE_W'(100);
      tick_ms_q   <= TICK_W'(1);
      pwm_inv_q   <= 1'b0;
      ttl_pres_q  <= 1'b0;
      ttl_inv_q   <= 1'b0;
      beam_q      <= 1'b0;
      manual_q    <= 1'b0;
      fire_rem_q  <= '0;
      duty_q      <= '0;
      rej_q       <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      state_q     <= ST_IDLE;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_addr_i))
          CFG_MAX_POWER:   max_power_q <= cfg_wdata_i;
          CFG_MIN_POWER:   min_power_q <= cfg_wdata_i;
          CFG_MAX_S_LEVEL: max_s_q     <= cfg_wdata_i[S_W-1:0];
          CFG_SCALE_PCT:   scale_q     <= cfg_wdata_i[SCALE_W-1:0];
          CFG_TICK_MS:     tick_ms_q   <= cfg_wdata_i[TICK_W-1:0];
          CFG_PWM_INVERT:  pwm_inv_q   <= cfg_wdata_i[0];
          CFG_TTL_PRESENT: ttl_pres_q  <= cfg_wdata_i[0];
          CFG_TTL_INVERT:  ttl_inv_q   <= cfg_wdata_i[0];
          default: ;
        endcase
      end

      if (out_valid_q && m_axis_tready) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            axis_q  <= in_axis;
            nom_q   <= in_nom;
            fms_q   <= in_fms;
            rej_q   <= 1'b0;
            state_q <= ST_OUT;
            unique case (in_op)
              OP_TICK: begin
                if (manual_q) begin
                  if (fire_rem_q != '0) begin
                    fire_rem_q <= rem_dec;
                    if (rem_dec == '0) begin
                      duty_q   <= '0;
                      beam_q   <= 1'b0;
                      manual_q <= 1'b0;
                    end
                  end
                end else if (in_move) begin
                  acc_q   <= {in_s, 16'b0, 28'b0};
                  rem_q   <= '0;
                  dvs_q   <= {8'b0, max_s_w};
                  cnt_q   <= CNT_W'(32);
                  state_q <= ST_REQ_DIV;
                end else begin
                  duty_q <= '0;
                  beam_q <= 1'b0;
                end
              end
              OP_FIRE: begin
                fire_rem_q <= '0;
                if (in_hund == '0) begin
                  duty_q   <= '0;
                  beam_q   <= 1'b0;
                  manual_q <= 1'b0;
                end else if (in_fms != '0 && in_fms < FMS_W'(tick_w)) begin
                  rej_q <= 1'b1;
                end else begin
                  acc_q   <= {hund_sat, 16'b0, 30'b0};
                  rem_q   <= '0;
                  dvs_q   <= HUND_DIV;
                  cnt_q   <= CNT_W'(30);
                  state_q <= ST_FIRE_DIV;
                end
              end
              OP_FIRE_OFF: begin
                fire_rem_q <= '0;
                duty_q     <= '0;
                beam_q     <= 1'b0;
                manual_q   <= 1'b0;
              end
              OP_HALT: begin
                duty_q   <= '0;
                beam_q   <= 1'b0;
                manual_q <= 1'b0;
              end
              default: ;
            endcase
          end
        end

        ST_REQ_DIV: begin
          acc_q <= div_d;
          rem_q <= rem_d;
          cnt_q <= cnt_q - CNT_W'(1);
          if (last_step) begin
            mcand_q <= {4'b0, div_d[31:0]};
            mlt_q   <= {scale_q, 14'b0};
            acc_q   <= '0;
            cnt_q   <= CNT_W'(SCALE_W);
            state_q <= ST_SCL_MUL;
          end
        end

        ST_SCL_MUL: begin
          acc_q <= mul_d;
          mlt_q <= {mlt_q[MLT_W-2:0], 1'b0};
          cnt_q <= cnt_q - CNT_W'(1);
          if (last_step) begin
            acc_q   <= {mul_d[41:0], 18'b0};
            rem_q   <= '0;
            dvs_q   <= PCT_DIV;
            cnt_q   <= CNT_W'(42);
            state_q <= ST_PCT_DIV;
          end
        end

        ST_PCT_DIV: begin
          acc_q <= div_d;
          rem_q <= rem_d;
          cnt_q <= cnt_q - CNT_W'(1);
          if (last_step) begin
            mcand_q <= div_d[MCAND_W-1:0];
            mlt_q   <= axis_q;
            acc_q   <= '0;
            cnt_q   <= CNT_W'(RATE_W);
            state_q <= ST_AXIS_MUL;
          end
        end

        ST_AXIS_MUL: begin
          acc_q <= mul_d;
          mlt_q <= {mlt_q[MLT_W-2:0], 1'b0};
          cnt_q <= cnt_q - CNT_W'(1);
          if (last_step) begin
            if (nom_q == '0) begin
              mcand_q <= '0;
              mlt_q   <= {span, 7'b0};
              acc_q   <= '0;
              cnt_q   <= CNT_W'(POWER_W);
              state_q <= ST_SPAN_MUL;
            end else begin
              acc_q   <= mul_d;
              rem_q   <= '0;
              dvs_q   <= nom_q;
              cnt_q   <= CNT_W'(ACC_W);
              state_q <= ST_RATE_DIV;
            end
          end
        end

        ST_RATE_DIV: begin
          acc_q <= div_d;
          rem_q <= rem_d;
          cnt_q <= cnt_q - CNT_W'(1);
          if (last_step) begin
            mcand_q <= cap_d[MCAND_W-1:0];
            mlt_q   <= {span, 7'b0};
            acc_q   <= '0;
            cnt_q   <= CNT_W'(POWER_W);
            state_q <= ST_SPAN_MUL;
          end
        end

        ST_SPAN_MUL: begin
          acc_q <= mul_d;
          mlt_q <= {mlt_q[MLT_W-2:0], 1'b0};
          cnt_q <= cnt_q - CNT_W'(1);
          if (last_step) begin
            state_q <= ST_MAP;
          end
        end

        ST_MAP: begin
          duty_q  <= map_duty;
          beam_q  <= (map_duty != '0);
          state_q <= ST_OUT;
        end

        ST_FIRE_DIV: begin
          acc_q <= div_d;
          rem_q <= rem_d;
          cnt_q <= cnt_q - CNT_W'(1);
          if (last_step) begin
            duty_q   <= div_d[POWER_W-1:0];
            beam_q   <= 1'b1;
            manual_q <= 1'b1;
            if (fms_q != '0) begin
              acc_q   <= {fms_q, 36'b0};
              rem_q   <= '0;
              dvs_q   <= DVS_W'(tick_w);
              cnt_q   <= CNT_W'(FMS_W);
              state_q <= ST_ROUND_DIV;
            end else begin
              state_q <= ST_OUT;
            end
          end
        end

        ST_ROUND_DIV: begin
          acc_q <= div_d;
          rem_q <= rem_d;
          cnt_q <= cnt_q - CNT_W'(1);
          if (last_step) begin
            fire_rem_q <= fms_q - rem_d;
            state_q    <= ST_OUT;
          end
        end

        ST_OUT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_data_q  <= {3'b000, rej_q, manual_q, beam_q,
                            ttl_pres_q & (beam_q ^ ttl_inv_q),
                            pwm_inv_q ? FULL_Q16 - duty_q : duty_q};
            state_q     <= ST_IDLE;
          end
        end

        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

### test/tb_laser_power_speed_scaler_top.sv
// Testbench: laser power scaler driven by random and directed commands, checked by a scoreboard.
`timescale 1ns / 1ps
module tb_laser_power_speed_scaler_top;
  import lpss_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned PHASES         = 8;
  localparam int unsigned PHASE_ITEMS    = 232;

  typedef struct {
    opcode_e     op;
    bit          move;
    bit [15:0]   s;
    bit [23:0]   axis;
    bit [23:0]   nominal;
    bit [13:0]   hund;
    bit [23:0]   fms;
  } laser_cmd_t;

  typedef struct {
    bit [16:0] duty;
    bit        ttl;
    bit        beam;
    bit        manual;
    bit        rejected;
  } laser_status_t;

  class duty_scoreboard;
    bit [16:0]     max_power_q;
    bit [16:0]     min_power_q;
    bit [15:0]     max_s_q;
    bit [9:0]      scale_q;
    bit [9:0]      tick_q;
    bit            pwm_inv_q;
    bit            ttl_present_q;
    bit            ttl_inv_q;
    bit            beam_q;
    bit            manual_q;
    bit [23:0]     remaining_q;
    bit [16:0]     duty_q;
    laser_status_t expected_q[$];
    int unsigned   errors;

    function new();
      max_power_q   = FULL_Q16;
      min_power_q   = '0;
      max_s_q       = 16'd2048;
      scale_q       = 10'd100;
      tick_q        = 10'd1;
      pwm_inv_q     = 1'b0;
      ttl_present_q = 1'b0;
      ttl_inv_q     = 1'b0;
      beam_q        = 1'b0;
      manual_q      = 1'b0;
      remaining_q   = '0;
      duty_q        = '0;
      errors        = 0;
    endfunction

    function void write_reg(cfg_idx_e idx, bit [16:0] val);
      case (idx)
        CFG_MAX_POWER:   max_power_q   = val;
        CFG_MIN_POWER:   min_power_q   = val;
        CFG_MAX_S_LEVEL: max_s_q       = val[15:0];
        CFG_SCALE_PCT:   scale_q       = val[9:0];
        CFG_TICK_MS:     tick_q        = val[9:0];
        CFG_PWM_INVERT:  pwm_inv_q     = val[0];
        CFG_TTL_PRESENT: ttl_present_q = val[0];
        CFG_TTL_INVERT:  ttl_inv_q     = val[0];
        default: ;
      endcase
    endfunction

    function bit set_beam(longint unsigned duty);
      if (duty > 65536) duty = 65536;
      duty_q = 17'(duty);
      beam_q = (duty != 0);
      return beam_q;
    endfunction

    function longint unsigned speed_duty(laser_cmd_t c);
      longint unsigned div_s;
      longint unsigned req;
      longint unsigned scaled;
      longint unsigned pw;
      longint unsigned d;
      longint          val;
      div_s  = (max_s_q != 0) ? longint'(max_s_q) : 1;
      req    = (longint'(c.s) << 16) / div_s;
      scaled = req * longint'(scale_q) / 100;
      pw     = (c.nominal != 0) ? (scaled * longint'(c.axis)) / longint'(c.nominal) : 0;
      if (pw > 64'h4_0000_0000) pw = 64'h4_0000_0000;
      if (max_power_q >= min_power_q) begin
        d   = (longint'(max_power_q - min_power_q) * pw) >> 16;
        val = longint'(min_power_q) + longint'(d);
      end else begin
        d   = (longint'(min_power_q - max_power_q) * pw) >> 16;
        val = longint'(min_power_q) - longint'(d);
      end
      if (val < 0) val = 0;
      if (val > 65536) val = 65536;
      return longint'(val);
    endfunction

    function void note_command(laser_cmd_t c);
      int unsigned   tick;
      int unsigned   h;
      bit            rej;
      laser_status_t r;
      tick = (tick_q != 0) ? tick_q : 1;
      rej  = 1'b0;
      case (c.op)
        OP_TICK: begin
          if (manual_q) begin
            if (remaining_q != 0) begin
              remaining_q = (remaining_q > tick) ? 24'(remaining_q - tick) : '0;
              if (remaining_q == 0) begin
                void'(set_beam(0));
                manual_q = 1'b0;
              end
            end
          end else if (c.move) begin
            void'(set_beam(speed_duty(c)));
          end else if (beam_q) begin
            void'(set_beam(0));
          end
        end
        OP_FIRE: begin
          remaining_q = '0;
          if (c.hund == 0) begin
            manual_q = set_beam(0);
          end else begin
            h = (c.hund > HUND_MAX) ? 10000 : c.hund;
            if (c.fms != 0 && c.fms < tick) begin
              rej = 1'b1;
            end else begin
              remaining_q = 24'((c.fms / tick) * tick);
              manual_q    = set_beam((longint'(h) << 16) / 10000);
            end
          end
        end
        OP_FIRE_OFF: begin
          remaining_q = '0;
          manual_q    = set_beam(0);
        end
        default: begin
          void'(set_beam(0));
          manual_q = 1'b0;
        end
      endcase
      r.duty     = pwm_inv_q ? 17'(FULL_Q16 - duty_q) : duty_q;
      r.ttl      = ttl_present_q & (beam_q ^ ttl_inv_q);
      r.beam     = beam_q;
      r.manual   = manual_q;
      r.rejected = rej;
      expected_q.push_back(r);
    endfunction

    function void compare_field(string name, int unsigned exp, int unsigned act);
      if (exp != act) begin
        errors++;
        $display("%0t %s expected %0d actual %0d", $time, name, exp, act);
      end
    endfunction

    function void check_result(logic [OUT_TDATA_W-1:0] data);
      laser_status_t e;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t unexpected transaction, expected none actual %h", $time, data);
        return;
      end
      e = expected_q.pop_front();
      compare_field("pwm_duty", e.duty, data[16:0]);
      compare_field("ttl_level", e.ttl, data[17]);
      compare_field("beam_on", e.beam, data[18]);
      compare_field("manual_mode", e.manual, data[19]);
      compare_field("fire_rejected", e.rejected, data[20]);
    endfunction
  endclass

  logic                    clk_i;
  logic                    rst_ni        = 1'b0;
  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  logic [IN_TDATA_W-1:0]   s_axis_tdata  = '0;
  logic [OPCODE_W-1:0]     s_axis_tuser  = '0;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0]  m_axis_tdata;
  logic                    cfg_we_i      = 1'b0;
  logic [CFG_ADDR_W-1:0]   cfg_addr_i    = '0;
  logic [CFG_DATA_W-1:0]   cfg_wdata_i   = '0;

  duty_scoreboard sb = new();
  bit             no_idle = 1'b0;
  int unsigned    idle_cycles = 0;

  laser_power_speed_scaler_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("tb_laser_power_speed_scaler_top failed");
        $finish;
      end
    end
  end

  initial begin
    int unsigned stall;
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 14);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (m_axis_tvalid !== 1'b1);
      sb.check_result(m_axis_tdata);
    end
  end

  task automatic write_cfg(cfg_idx_e idx, bit [16:0] val);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    sb.write_reg(idx, val);
    @(posedge clk_i);
  endtask

  task automatic apply_cfg(bit [16:0] mp, bit [16:0] mn, bit [16:0] ms, bit [16:0] sc,
                           bit [16:0] tk, bit pi, bit tp, bit ti);
    write_cfg(CFG_MAX_POWER, mp);
    write_cfg(CFG_MIN_POWER, mn);
    write_cfg(CFG_MAX_S_LEVEL, ms);
    write_cfg(CFG_SCALE_PCT, sc);
    write_cfg(CFG_TICK_MS, tk);
    write_cfg(CFG_PWM_INVERT, pi);
    write_cfg(CFG_TTL_PRESENT, tp);
    write_cfg(CFG_TTL_INVERT, ti);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic send_cmd(laser_cmd_t c);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= c.op;
    s_axis_tdata  <= {1'b0, c.fms, c.hund, c.nominal, c.axis, c.s, c.move};
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
    sb.note_command(c);
  endtask

  function automatic laser_cmd_t make_cmd(opcode_e op, bit move, bit [15:0] s,
                                          bit [23:0] axis, bit [23:0] nominal,
                                          bit [13:0] hund, bit [23:0] fms);
    laser_cmd_t c;
    c.op = op; c.move = move; c.s = s; c.axis = axis;
    c.nominal = nominal; c.hund = hund; c.fms = fms;
    return c;
  endfunction

  function automatic laser_cmd_t random_cmd();
    laser_cmd_t  c;
    int unsigned r;
    int unsigned tk;
    int unsigned s_top;
    int unsigned a_top;
    c.move    = 1'($urandom);
    c.s       = 16'($urandom);
    c.axis    = 24'($urandom);
    c.nominal = 24'($urandom);
    c.hund    = 14'($urandom);
    c.fms     = 24'($urandom);
    tk    = (sb.tick_q != 0) ? sb.tick_q : 1;
    s_top = ((sb.max_s_q != 0) ? sb.max_s_q : 1) * 2;
    if (s_top > 65535) s_top = 65535;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      c.op   = OP_TICK;
      c.move = ($urandom_range(0, 99) < 85);
      if ($urandom_range(0, 3) != 0) c.s = 16'($urandom_range(0, s_top));
      case ($urandom_range(0, 7))
        0: c.nominal = '0;
        1: ;
        default: begin
          c.nominal = 24'($urandom_range(1, 24'hFFFFFF) >> $urandom_range(0, 23));
          if (c.nominal == 0) c.nominal = 24'd1;
          a_top = c.nominal + c.nominal / 4;
          if (a_top > 24'hFFFFFF) a_top = 24'hFFFFFF;
          c.axis = 24'($urandom_range(0, a_top));
        end
      endcase
    end else if (r < 78) begin
      c.op = OP_FIRE;
      case ($urandom_range(0, 9))
        0: c.hund = '0;
        1: c.hund = 14'($urandom_range(10001, 16383));
        default: c.hund = 14'($urandom_range(1, 10000));
      endcase
      r = $urandom_range(0, 19);
      if (r < 3) c.fms = '0;
      else if (r < 6) c.fms = 24'($urandom_range(1, (tk > 1) ? tk - 1 : 1));
      else if (r < 8) c.fms = 24'($urandom);
      else c.fms = 24'(tk * $urandom_range(1, 10) + $urandom_range(0, tk - 1));
    end else if (r < 89) begin
      c.op = OP_FIRE_OFF;
    end else begin
      c.op = OP_HALT;
    end
    return c;
  endfunction

  initial begin
    bit [16:0] mp;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_cmd(make_cmd(OP_TICK, 1'b0, 16'd2048, 24'd1000, 24'd1000, '0, '0));
    send_cmd(make_cmd(OP_TICK, 1'b1, 16'd2048, 24'd1000, 24'd1000, '0, '0));
    send_cmd(make_cmd(OP_TICK, 1'b0, 16'd0, 24'd0, 24'd0, '0, '0));
    send_cmd(make_cmd(OP_TICK, 1'b1, 16'hFFFF, 24'hFFFFFF, 24'd1, 14'h3FFF, 24'hFFFFFF));
    send_cmd(make_cmd(OP_TICK, 1'b1, 16'd1024, 24'd500, 24'd0, '0, '0));
    send_cmd(make_cmd(OP_TICK, 1'b1, 16'd0, 24'hFFFFFF, 24'hFFFFFF, '0, '0));
    send_cmd(make_cmd(OP_FIRE, 1'b0, '0, '0, '0, 14'd0, 24'd123));
    send_cmd(make_cmd(OP_FIRE, 1'b0, '0, '0, '0, 14'h3FFF, 24'd0));
    send_cmd(make_cmd(OP_TICK, 1'b1, 16'd2048, 24'd10, 24'd10, '0, '0));
    send_cmd(make_cmd(OP_HALT, 1'b0, '0, '0, '0, '0, '0));
    send_cmd(make_cmd(OP_FIRE, 1'b0, '0, '0, '0, 14'd1, 24'd3));
    repeat (3) send_cmd(make_cmd(OP_TICK, 1'b1, 16'd100, 24'd5, 24'd5, '0, '0));
    send_cmd(make_cmd(OP_FIRE, 1'b0, '0, '0, '0, 14'd5000, 24'hFFFFFF));
    send_cmd(make_cmd(OP_FIRE_OFF, 1'b0, '0, '0, '0, '0, '0));
    wait_idle();

    apply_cfg(17'd1000, 17'd60000, 17'd0, 17'd1000, 17'd7, 1'b1, 1'b1, 1'b1);
    send_cmd(make_cmd(OP_FIRE, 1'b0, '0, '0, '0, 14'd10000, 24'd3));
    send_cmd(make_cmd(OP_FIRE, 1'b0, '0, '0, '0, 14'd2500, 24'd20));
    send_cmd(make_cmd(OP_TICK, 1'b0, '0, '0, '0, '0, '0));
    send_cmd(make_cmd(OP_HALT, 1'b0, '0, '0, '0, '0, '0));
    send_cmd(make_cmd(OP_TICK, 1'b1, 16'd1, 24'd1, 24'd1, '0, '0));
    send_cmd(make_cmd(OP_TICK, 1'b1, 16'd1, 24'd9, 24'd0, '0, '0));
    send_cmd(make_cmd(OP_FIRE_OFF, 1'b0, '0, '0, '0, '0, '0));
    wait_idle();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: apply_cfg(17'd0, FULL_Q16, 17'd0, 17'd1000, 17'd0, 1'b1, 1'b1, 1'b1);
        1: apply_cfg(FULL_Q16, 17'd0, 17'd65535, 17'd0, 17'd1000, 1'b0, 1'b1, 1'b0);
        2: apply_cfg(FULL_Q16, 17'd0, 17'd2048, 17'd100, 17'd1, 1'b0, 1'b0, 1'b0);
        default: begin
          mp = 17'($urandom_range(0, 65536));
          apply_cfg(mp,
                    ($urandom_range(0, 3) == 0) ? 17'($urandom_range(0, 65536))
                                                : 17'($urandom_range(0, mp)),
                    17'($urandom_range(0, 65535)),
                    17'($urandom_range(0, 1000)),
                    ($urandom_range(0, 2) == 0) ? 17'($urandom_range(0, 10))
                                                : 17'($urandom_range(1, 1000)),
                    1'($urandom), 1'($urandom), 1'($urandom));
        end
      endcase
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i % 50 == 0) no_idle = ($urandom_range(0, 4) == 0);
        send_cmd(random_cmd());
      end
      wait_idle();
    end

    no_idle = 1'b0;
    repeat (200) @(posedge clk_i);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("tb_laser_power_speed_scaler_top passed");
    end else begin
      $display("tb_laser_power_speed_scaler_top failed");
    end
    $finish;
  end

endmodule
